// File: src/lwpc_pkg.sv
// Package of the page cache directory: sizes, field widths, action and
// register codes, and the command and status structs between controller
// and datapath. Depends on nothing.
package lwpc_pkg;

	localparam int SLOTS      = 8;
	localparam int PAGE_BYTES = 512;

	localparam int SLOT_W   = $clog2(SLOTS);
	localparam int POFF_W   = $clog2(PAGE_BYTES);
	localparam int COORD_W  = 12;               // coordinate bits used in the offset (below 4096)
	localparam int DIM_W    = 13;               // canvas_width / canvas_height
	localparam int OFFSET_W = 24;               // 4095 * 4096 + 4095 fits
	localparam int PAGE_W   = OFFSET_W - POFF_W;
	localparam int SECT_W   = 32;
	localparam int STAMP_W  = 32;

	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 88;
	localparam int OUT_USER_W = 5;

	localparam logic [7:0]         BLANK_BYTE = 8'h20;
	localparam logic [STAMP_W-1:0] STAMP_MAX  = 32'hFFFF_FFFF;

	typedef enum logic [1:0] {
		ACT_READ  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_FLUSH = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	localparam logic [1:0] CFG_BASE   = 2'd0;
	localparam logic [1:0] CFG_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_HEIGHT = 2'd2;

	typedef struct packed {
		logic load;         // capture an accepted item, restart the slot counter
		logic calc_mul;     // row product and bounds check
		logic calc_add;     // linear offset
		logic scan_step;    // tag and victim check of one slot
		logic cnt_skip;     // flush: step past a clean slot
		logic access_emit;  // update directory, load access result
		logic oor_emit;     // load out-of-range result
		logic flush_emit;   // clean one slot, load writeback result
	} cmd_t;

	typedef struct packed {
		logic oor;
		logic cnt_last;
		logic flush_hit;
		logic out_free;
	} sts_t;

endpackage

// File: src/lwpc_ctrl.sv
// Controller of the page cache directory: sequences bounds check, offset,
// slot scan, directory update and flush. Depends on lwpc_pkg.
module lwpc_ctrl
	import lwpc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [1:0] s_tuser,
	input  sts_t       sts,
	output cmd_t       cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ADD,
		ST_SCAN,
		ST_UPD,
		ST_OOR,
		ST_FLUSH
	} state_t;

	state_t state_q;
	logic   accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		cmd             = '0;
		cmd.load        = accept;
		cmd.calc_mul    = (state_q == ST_MUL);
		cmd.calc_add    = (state_q == ST_ADD);
		cmd.scan_step   = (state_q == ST_SCAN);
		cmd.access_emit = (state_q == ST_UPD) && sts.out_free;
		cmd.oor_emit    = (state_q == ST_OOR) && sts.out_free;
		cmd.flush_emit  = (state_q == ST_FLUSH) && sts.flush_hit && sts.out_free;
		cmd.cnt_skip    = (state_q == ST_FLUSH) && !sts.flush_hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (action_t'(s_tuser))
							ACT_FLUSH: state_q <= ST_FLUSH;
							ACT_NONE:  state_q <= ST_IDLE;
							default:   state_q <= ST_MUL;
						endcase
					end
				end
				ST_MUL: state_q <= ST_ADD;
				ST_ADD: state_q <= sts.oor ? ST_OOR : ST_SCAN;
				ST_SCAN: begin
					if (sts.cnt_last) state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				ST_OOR: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				ST_FLUSH: begin
					// hold on a dirty slot until the result register is free
					if (sts.cnt_last && (!sts.flush_hit || sts.out_free)) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// File: src/lwpc_dp.sv
// Datapath of the page cache directory: configuration registers, slot
// directory, address arithmetic, scan trackers and result register.
// Depends on lwpc_pkg.
module lwpc_dp
	import lwpc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [31:0]           cfg_data,
	input  logic [IN_DATA_W-1:0]  s_tdata,
	input  logic [1:0]            s_tuser,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,
	output logic [OUT_USER_W-1:0] m_tuser,
	output logic                  m_tlast
);

	logic [SECT_W-1:0] base_q;
	logic [DIM_W-1:0]  width_q;
	logic [DIM_W-1:0]  height_q;

	logic [PAGE_W-1:0]  slot_page_q  [SLOTS];
	logic [STAMP_W-1:0] slot_stamp_q [SLOTS];
	logic [SLOTS-1:0]   slot_valid_q;
	logic [SLOTS-1:0]   slot_dirty_q;
	logic [STAMP_W-1:0] use_q;

	logic [1:0]          act_q;
	logic [15:0]         x_q;
	logic [15:0]         y_q;
	logic [7:0]          pix_q;
	logic [OFFSET_W-1:0] prod_q;
	logic                oor_q;
	logic [OFFSET_W-1:0] offset_q;

	logic [SLOT_W-1:0]  cnt_q;
	logic               hit_q;
	logic [SLOT_W-1:0]  hslot_q;
	logic               found_inv_q;
	logic [STAMP_W-1:0] oldest_q;
	logic [SLOT_W-1:0]  victim_q;
	logic [PAGE_W-1:0]  vpage_q;
	logic               vdirty_q;

	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [OUT_USER_W-1:0] out_user_q;
	logic                  out_last_q;

	logic [PAGE_W-1:0] req_page;
	logic [POFF_W-1:0] req_poff;
	logic              is_write;
	logic              cnt_last;
	logic              match;
	logic              flush_more;
	logic [SLOTS-1:0]  dirty_mask;
	logic [SLOT_W-1:0] acc_slot;
	logic              acc_wb;
	logic [SECT_W-1:0] acc_wbsec;
	logic [SECT_W-1:0] acc_fsec;
	logic [SECT_W-1:0] fl_wbsec;

	assign req_page   = offset_q[OFFSET_W-1:POFF_W];
	assign req_poff   = offset_q[POFF_W-1:0];
	assign is_write   = (act_q == ACT_WRITE);
	assign cnt_last   = (cnt_q == SLOT_W'(SLOTS - 1));
	assign match      = slot_valid_q[cnt_q] && (slot_page_q[cnt_q] == req_page);
	assign dirty_mask = slot_valid_q & slot_dirty_q;

	always_comb begin
		flush_more = 1'b0;
		for (int j = 0; j < SLOTS; j++) begin
			if ((SLOT_W'(j) > cnt_q) && dirty_mask[j]) flush_more = 1'b1;
		end
	end

	assign acc_slot  = hit_q ? hslot_q : victim_q;
	assign acc_wb    = !hit_q && vdirty_q;
	assign acc_wbsec = acc_wb ? (base_q + SECT_W'(vpage_q)) : '0;
	assign acc_fsec  = hit_q ? '0 : (base_q + SECT_W'(req_page));
	assign fl_wbsec  = base_q + SECT_W'(slot_page_q[cnt_q]);

	assign sts.oor       = oor_q;
	assign sts.cnt_last  = cnt_last;
	assign sts.flush_hit = dirty_mask[cnt_q];
	assign sts.out_free  = !out_valid_q || m_tready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			width_q  <= DIM_W'(640);
			height_q <= DIM_W'(480);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BASE:   base_q   <= cfg_data;
				CFG_WIDTH:  width_q  <= cfg_data[DIM_W-1:0];
				CFG_HEIGHT: height_q <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// item capture and address arithmetic
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= s_tuser;
			x_q   <= s_tdata[15:0];
			y_q   <= s_tdata[31:16];
			pix_q <= s_tdata[39:32];
		end
		if (cmd.calc_mul) begin
			prod_q <= OFFSET_W'(y_q[COORD_W-1:0] * width_q);
			oor_q  <= x_q[15] || y_q[15]
				|| (x_q >= {3'b000, width_q}) || (y_q >= {3'b000, height_q});
		end
		if (cmd.calc_add) begin
			offset_q <= prod_q + OFFSET_W'(x_q[COORD_W-1:0]);
		end
	end

	// slot counter and scan trackers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
		end else if (cmd.scan_step || cmd.cnt_skip || cmd.flush_emit) begin
			cnt_q <= cnt_last ? '0 : cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			hit_q <= 1'b0;
		end else if (cmd.scan_step) begin
			if (match && !hit_q) begin
				hit_q   <= 1'b1;
				hslot_q <= cnt_q;
			end
			if (cnt_q == '0) begin
				// slot zero seeds the victim, also when every stamp is at maximum
				found_inv_q <= !slot_valid_q[0];
				oldest_q    <= slot_stamp_q[0];
				victim_q    <= '0;
				vpage_q     <= slot_page_q[0];
				vdirty_q    <= dirty_mask[0];
			end else if (!found_inv_q) begin
				if (!slot_valid_q[cnt_q]) begin
					found_inv_q <= 1'b1;
					victim_q    <= cnt_q;
					vdirty_q    <= 1'b0;
				end else if (slot_stamp_q[cnt_q] < oldest_q) begin
					oldest_q <= slot_stamp_q[cnt_q];
					victim_q <= cnt_q;
					vpage_q  <= slot_page_q[cnt_q];
					vdirty_q <= slot_dirty_q[cnt_q];
				end
			end
		end
	end

	// directory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			slot_dirty_q <= '0;
			use_q        <= '0;
		end else if (cmd.access_emit) begin
			use_q <= use_q + 1'b1;
			if (!hit_q) begin
				slot_valid_q[acc_slot] <= 1'b1;
				slot_dirty_q[acc_slot] <= is_write;
			end else if (is_write) begin
				slot_dirty_q[acc_slot] <= 1'b1;
			end
		end else if (cmd.flush_emit) begin
			slot_dirty_q[cnt_q] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.access_emit) begin
			slot_stamp_q[acc_slot] <= use_q + 1'b1;
			if (!hit_q) slot_page_q[acc_slot] <= req_page;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.access_emit || cmd.oor_emit || cmd.flush_emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.access_emit) begin
			out_data_q <= {4'b0000, acc_fsec, acc_wbsec, (is_write ? pix_q : 8'h00),
				req_poff, acc_slot};
			out_user_q <= {!hit_q, acc_wb, is_write, hit_q, 1'b0};
			out_last_q <= 1'b1;
		end else if (cmd.oor_emit) begin
			out_data_q <= {4'b0000, {SECT_W{1'b0}}, {SECT_W{1'b0}},
				(is_write ? 8'h00 : BLANK_BYTE), {POFF_W{1'b0}}, {SLOT_W{1'b0}}};
			out_user_q <= {4'b0000, 1'b1};
			out_last_q <= 1'b1;
		end else if (cmd.flush_emit) begin
			out_data_q <= {4'b0000, {SECT_W{1'b0}}, fl_wbsec, 8'h00,
				{POFF_W{1'b0}}, cnt_q};
			out_user_q <= {1'b0, 1'b1, 1'b0, 1'b0, 1'b0};
			out_last_q <= !flush_more;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_user_q;
	assign m_tlast  = out_last_q;

endmodule

// File: src/lru_writeback_page_cache_unit.sv
// Top level of the write-back page cache directory: joins controller and
// datapath. Depends on lwpc_pkg, lwpc_ctrl and lwpc_dp.
//
// Use: requests enter on the s_ stream (action in s_tuser; 0 read pixel,
// 1 write pixel, 2 flush, 3 ignored). Each transfer on the m_ stream tells
// the page RAM and the sector mover what to do: slot and in-page offset,
// optional RAM write, a writeback of the old page and a fill of the new one.
// Configuration (base sector, canvas width and height) goes in over the
// cfg_ write port while no request is in flight.
// Throughput: one item at a time. A read or write passes through the row
// product and bounds check, the offset, the tag and LRU scan (one slot per
// cycle through the directory read port) and the update, which loads the
// result; the next item is taken after that. An out-of-range request skips
// the scan and loads its result in its own step. A flush walks the slots one
// per cycle, holding on a dirty slot while the result register is not free,
// and emits one writeback per dirty slot, tlast on the final one.
// Stall: a single result register holds while m_tready is low; the
// controller holds at its emit step until that register frees.
// Reset: arst_n clears all slots to invalid and clean, the access stamp
// counter to zero, and the canvas to 640 by 480 at sector zero.
module lru_writeback_page_cache_unit
	import lwpc_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_index,
	input  logic [31:0]           cfg_data,
	// request stream
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // pos_x[15:0], pos_y[31:16], pixel_byte[39:32]
	input  logic [1:0]            s_tuser,  // action[1:0]
	// result stream
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // slot[2:0], byte_pos[11:3],
	                                        // write_byte[19:12], writeback_sector[51:20],
	                                        // fill_sector[83:52], zero[87:84]
	output logic [OUT_USER_W-1:0] m_tuser,  // out_of_range[0], hit[1], ram_write[2],
	                                        // writeback[3], fill[4]
	output logic                  m_tlast   // last
);

	cmd_t cmd;
	sts_t sts;

	// sequence the steps of each request
	lwpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.sts      (sts),
		.cmd      (cmd)
	);

	// directory, arithmetic and result register
	lwpc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

endmodule

// File: src/lwpc_checker.sv
// Port checker of the page cache directory, bound to the top level.
// Depends on lwpc_pkg and lru_writeback_page_cache_unit.
module lwpc_props
	import lwpc_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [1:0]            s_tuser,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic [OUT_USER_W-1:0] m_tuser,
	input logic                  m_tlast
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// one item at a time: busy after taking a real request
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser != ACT_NONE) |=> !s_tready)
		else $error("request taken while another is in flight");

	// out of range touches nothing
	a_oor: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> (m_tuser[4:1] == '0) && m_tlast)
		else $error("out-of-range result carries an action");

	// a hit needs no sector traffic
	a_hit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> !m_tuser[3] && !m_tuser[4] && m_tlast)
		else $error("hit with writeback or fill");

endmodule

bind lru_writeback_page_cache_unit lwpc_props u_lwpc_props (.*);
